### design/mmbd_pkg.sv
// shared types and constants of the memory map bus decoder
`timescale 1ns / 1ps

package mmbd_pkg;

	// bus operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_IRQ   = 2'd2;

	// result target codes
	localparam logic [2:0] TGT_INTERNAL = 3'd0;
	localparam logic [2:0] TGT_BOOT     = 3'd1;
	localparam logic [2:0] TGT_CART     = 3'd2;
	localparam logic [2:0] TGT_VIDEO    = 3'd3;
	localparam logic [2:0] TGT_JOYPAD   = 3'd4;
	localparam logic [2:0] TGT_TIMER    = 3'd5;
	localparam logic [2:0] TGT_DMA      = 3'd6;
	localparam logic [2:0] TGT_UNMAPPED = 3'd7;

	// fixed addresses of the map
	localparam logic [15:0] ADDR_WRAM_LO  = 16'hC000;
	localparam logic [15:0] ADDR_ECHO_LO  = 16'hE000;
	localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
	localparam logic [15:0] ADDR_IF       = 16'hFF0F;
	localparam logic [15:0] ADDR_DMA      = 16'hFF46;
	localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
	localparam logic [15:0] ADDR_HRAM_LO  = 16'hFF80;
	localparam logic [15:0] ADDR_IE       = 16'hFFFF;

	localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic load_now;
		logic load_ram;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic ram_read;
	} sts_t;

endpackage

### design/memory_map_bus_decoder.sv
// top level of the memory map bus decoder
`timescale 1ns / 1ps
//
// bus access decoder for an 8-bit machine's 16-bit memory map
// input channel: in_valid/in_ready carry one item (operation, address,
//   write_data, interrupt_bit); output channel: out_valid/out_ready carry one
//   result item (target, read_data, forward_address, forward_write, forward_data)
// every accepted item yields exactly one result item, in order
// results are registered; reads of work ram or high ram pass first through the
//   registered ram read port and then through the result register
// throughput: one item per cycle while the receiver keeps taking results, except
//   a ram read holds the input while its data comes out of the ram
// the result sits in an output register, so the next item is taken in the
//   cycle the previous result is taken; while the receiver stalls, in_ready
//   stays low and the result holds
// reset: flags, enables and the boot-rom flag take their reset values at
//   once; then a clearing pass writes zeros through all of work ram (and high
//   ram alongside), one entry per cycle, WORK_RAM_DEPTH entries (8192 by
//   default), with in_ready low for its whole length
// a nonzero write to the boot-off register maps the boot rom out for good
//
module memory_map_bus_decoder #(
	parameter int WORK_RAM_DEPTH = 8192,
	parameter int HIGH_RAM_DEPTH = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [2:0]  interrupt_bit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  target,
	output logic [7:0]  read_data,
	output logic [15:0] forward_address,
	output logic        forward_write,
	output logic [7:0]  forward_data
);

	mmbd_pkg::cmd_t cmd;
	mmbd_pkg::sts_t sts;

	// sequencing: clearing pass, idle, wait for ram read data
	mmbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// decode, internal storage and result registers
	mmbd_dp #(
		.WORK_RAM_DEPTH(WORK_RAM_DEPTH),
		.HIGH_RAM_DEPTH(HIGH_RAM_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.address        (address),
		.write_data     (write_data),
		.interrupt_bit  (interrupt_bit),
		.target         (target),
		.read_data      (read_data),
		.forward_address(forward_address),
		.forward_write  (forward_write),
		.forward_data   (forward_data)
	);

	// a ram read item delivers its data in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.ram_read) |=> cmd.load_ram)
		else $error("ram read not followed by result load");

	// no item is taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !in_ready)
		else $error("input ready during clearing pass");

	// an item is only taken when the output slot frees up
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input taken while result is stalled");

	// the output register is never loaded twice at once
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_ram |-> !in_ready)
		else $error("new item accepted while ram data pending");

endmodule

### design/mmbd_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module mmbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/mmbd_ctrl.sv
// controller state machine of the memory map bus decoder
`timescale 1ns / 1ps

module mmbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mmbd_pkg::sts_t sts,
	output mmbd_pkg::cmd_t cmd
);

	mmbd_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic accept;

	always_comb begin
		in_ready = (state_q == mmbd_pkg::ST_IDLE) && (!out_valid_q || out_ready);
		accept   = in_valid && in_ready;
		cmd.clear    = (state_q == mmbd_pkg::ST_CLEAR);
		cmd.accept   = accept;
		cmd.load_now = accept && !sts.ram_read;
		cmd.load_ram = (state_q == mmbd_pkg::ST_RDWAIT);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmbd_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = mmbd_pkg::ST_IDLE;
				end
			end
			mmbd_pkg::ST_IDLE: begin
				if (accept && sts.ram_read) begin
					state_d = mmbd_pkg::ST_RDWAIT;
				end
			end
			mmbd_pkg::ST_RDWAIT: begin
				state_d = mmbd_pkg::ST_IDLE;
			end
			default: begin
				state_d = mmbd_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmbd_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_now || cmd.load_ram) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/mmbd_dp.sv
// address decode, internal storage and result registers
`timescale 1ns / 1ps

module mmbd_dp #(
	parameter int WORK_RAM_DEPTH = 8192,
	parameter int HIGH_RAM_DEPTH = 127
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mmbd_pkg::cmd_t cmd,
	output mmbd_pkg::sts_t sts,
	input  logic [1:0]     operation,
	input  logic [15:0]    address,
	input  logic [7:0]     write_data,
	input  logic [2:0]     interrupt_bit,
	output logic [2:0]     target,
	output logic [7:0]     read_data,
	output logic [15:0]    forward_address,
	output logic           forward_write,
	output logic [7:0]     forward_data
);

	localparam int WA = $clog2(WORK_RAM_DEPTH);
	localparam int HA = $clog2(HIGH_RAM_DEPTH);

	logic [WA-1:0] clr_cnt_q;
	logic [7:0]    if_q, ie_q;
	logic          boot_q;
	logic          rd_hram_q;

	logic [2:0]  target_q;
	logic [7:0]  read_data_q;
	logic [15:0] forward_address_q;
	logic        forward_write_q;
	logic [7:0]  forward_data_q;

	logic        wr, is_wram, is_hram;
	logic [2:0]  dec_tgt, tgt_c;
	logic [7:0]  rd_c, fd_c;
	logic [15:0] fa_c;
	logic        fw_c, ram_rd_c;
	logic        hram_clr;
	logic [7:0]  wram_rdata, hram_rdata;

	always_comb begin
		wr      = (operation == mmbd_pkg::OP_WRITE);
		is_wram = (address >= mmbd_pkg::ADDR_WRAM_LO) && (address <= 16'hFDFF);
		is_hram = (address >= mmbd_pkg::ADDR_HRAM_LO) && (address != mmbd_pkg::ADDR_IE);

		if (address <= 16'h7FFF) begin
			dec_tgt = (!wr && boot_q && address[15:8] == 8'h00) ?
				mmbd_pkg::TGT_BOOT : mmbd_pkg::TGT_CART;
		end else if (address <= 16'h9FFF) begin
			dec_tgt = mmbd_pkg::TGT_VIDEO;
		end else if (address < mmbd_pkg::ADDR_WRAM_LO) begin
			dec_tgt = mmbd_pkg::TGT_CART;
		end else if (address <= 16'hFDFF) begin
			dec_tgt = mmbd_pkg::TGT_INTERNAL;
		end else if (address <= 16'hFE9F) begin
			dec_tgt = mmbd_pkg::TGT_VIDEO;
		end else if (address < mmbd_pkg::ADDR_JOYPAD) begin
			dec_tgt = mmbd_pkg::TGT_UNMAPPED;
		end else if (address < mmbd_pkg::ADDR_HRAM_LO) begin
			if (address == mmbd_pkg::ADDR_JOYPAD) begin
				dec_tgt = mmbd_pkg::TGT_JOYPAD;
			end else if (address inside {[16'hFF04:16'hFF07]}) begin
				dec_tgt = mmbd_pkg::TGT_TIMER;
			end else if (address == mmbd_pkg::ADDR_IF) begin
				dec_tgt = mmbd_pkg::TGT_INTERNAL;
			end else if (wr && address == mmbd_pkg::ADDR_DMA) begin
				dec_tgt = mmbd_pkg::TGT_DMA;
			end else if (wr && address == mmbd_pkg::ADDR_BOOT_OFF && write_data != 8'h00) begin
				dec_tgt = mmbd_pkg::TGT_INTERNAL;
			end else if (address inside {[16'hFF40:16'hFF4B]}) begin
				dec_tgt = mmbd_pkg::TGT_VIDEO;
			end else begin
				dec_tgt = mmbd_pkg::TGT_UNMAPPED;
			end
		end else begin
			dec_tgt = mmbd_pkg::TGT_INTERNAL;
		end

		tgt_c    = mmbd_pkg::TGT_UNMAPPED;
		rd_c     = mmbd_pkg::BYTE_UNMAPPED;
		fa_c     = 16'h0000;
		fw_c     = 1'b0;
		fd_c     = 8'h00;
		ram_rd_c = 1'b0;
		case (operation)
			mmbd_pkg::OP_IRQ: begin
				tgt_c = mmbd_pkg::TGT_INTERNAL;
				rd_c  = 8'h00;
			end
			mmbd_pkg::OP_READ, mmbd_pkg::OP_WRITE: begin
				tgt_c = dec_tgt;
				if (dec_tgt == mmbd_pkg::TGT_UNMAPPED) begin
					rd_c = mmbd_pkg::BYTE_UNMAPPED;
				end else if (dec_tgt == mmbd_pkg::TGT_INTERNAL) begin
					rd_c     = 8'h00;
					ram_rd_c = !wr && (is_wram || is_hram);
					if (!wr && address == mmbd_pkg::ADDR_IF) begin
						rd_c = if_q;
					end else if (!wr && address == mmbd_pkg::ADDR_IE) begin
						rd_c = ie_q;
					end
				end else begin
					rd_c = 8'h00;
					fa_c = address;
					fw_c = wr;
					fd_c = wr ? write_data : 8'h00;
				end
			end
			default: begin
				tgt_c = mmbd_pkg::TGT_UNMAPPED;
				rd_c  = mmbd_pkg::BYTE_UNMAPPED;
			end
		endcase

		sts.ram_read   = ram_rd_c;
		sts.clear_last = (clr_cnt_q == WA'(WORK_RAM_DEPTH - 1));
		hram_clr       = cmd.clear && (clr_cnt_q < WA'(HIGH_RAM_DEPTH));
	end

	mmbd_ram #(
		.WIDTH(8),
		.DEPTH(WORK_RAM_DEPTH)
	) u_wram (
		.clk  (clk),
		.we   (cmd.clear || (cmd.accept && wr && is_wram)),
		.waddr(cmd.clear ? clr_cnt_q : address[WA-1:0]),
		.wdata(cmd.clear ? 8'h00 : write_data),
		.re   (cmd.accept && ram_rd_c && is_wram),
		.raddr(address[WA-1:0]),
		.rdata(wram_rdata)
	);

	// high ram offset from its base is the low address bits
	mmbd_ram #(
		.WIDTH(8),
		.DEPTH(HIGH_RAM_DEPTH)
	) u_hram (
		.clk  (clk),
		.we   (hram_clr || (cmd.accept && wr && is_hram)),
		.waddr(cmd.clear ? clr_cnt_q[HA-1:0] : address[HA-1:0]),
		.wdata(cmd.clear ? 8'h00 : write_data),
		.re   (cmd.accept && ram_rd_c && is_hram),
		.raddr(address[HA-1:0]),
		.rdata(hram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			if_q      <= 8'h00;
			ie_q      <= 8'h00;
			boot_q    <= 1'b1;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + WA'(1);
			end
			if (cmd.accept) begin
				if (operation == mmbd_pkg::OP_IRQ) begin
					if_q <= if_q | 8'(8'd1 << interrupt_bit);
				end else if (wr && address == mmbd_pkg::ADDR_IF) begin
					if_q <= write_data;
				end
				if (wr && address == mmbd_pkg::ADDR_IE) begin
					ie_q <= write_data;
				end
				if (wr && address == mmbd_pkg::ADDR_BOOT_OFF && write_data != 8'h00) begin
					boot_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_hram_q <= is_hram;
		end
		if (cmd.load_now) begin
			target_q          <= tgt_c;
			read_data_q       <= rd_c;
			forward_address_q <= fa_c;
			forward_write_q   <= fw_c;
			forward_data_q    <= fd_c;
		end else if (cmd.load_ram) begin
			target_q          <= mmbd_pkg::TGT_INTERNAL;
			read_data_q       <= rd_hram_q ? hram_rdata : wram_rdata;
			forward_address_q <= 16'h0000;
			forward_write_q   <= 1'b0;
			forward_data_q    <= 8'h00;
		end
	end

	assign target          = target_q;
	assign read_data       = read_data_q;
	assign forward_address = forward_address_q;
	assign forward_write   = forward_write_q;
	assign forward_data    = forward_data_q;

endmodule

### tb/sv/tb_memory_map_bus_decoder.sv
// self-checking testbench of the memory map bus decoder
`timescale 1ns / 1ps

module tb_memory_map_bus_decoder;

	// operation code that the block must treat as a no-op
	localparam logic [1:0] OP_UNDEF = 2'd3;

	localparam int WRAM_WORDS = 8192;
	localparam int HRAM_WORDS = 127;
	localparam int RANDOM_ITEMS = 1800;
	// the boot rom is switched off partway through the random part
	localparam int BOOT_OFF_AT = 900;
	// the sender waits for a full drain before this random item
	localparam int DRAIN_AT = 1200;
	// long receiver hold-off once this many items went in
	localparam int HOLD_AFTER = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [2:0]  interrupt_bit;
		logic        drain_first;
	} bus_access_t;

	typedef struct {
		logic [2:0]  target;
		logic [7:0]  read_data;
		logic [15:0] forward_address;
		logic        forward_write;
		logic [7:0]  forward_data;
	} bus_result_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = mmbd_pkg::OP_READ;
	logic [15:0] address = 16'h0000;
	logic [7:0]  write_data = 8'h00;
	logic [2:0]  interrupt_bit = 3'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  target;
	logic [7:0]  read_data;
	logic [15:0] forward_address;
	logic        forward_write;
	logic [7:0]  forward_data;

	// pending accesses for the driver, expected results for the monitor
	bus_access_t access_queue[$];
	bus_result_t expected_results[$];

	// our own copy of the block's storage
	logic [7:0] wram_copy [0:WRAM_WORDS-1];
	logic [7:0] hram_copy [0:HRAM_WORDS-1];
	logic [7:0] if_copy;
	logic [7:0] ie_copy;
	logic       boot_on_copy;

	int offered_count = 0;
	int taken_count = 0;
	int result_count = 0;
	int error_count = 0;

	// sender burst state
	int burst_left = 0;
	int gap_left = 0;

	// receiver state
	rx_mode_t rx_mode = RX_ALWAYS;
	int mode_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	memory_map_bus_decoder DUT (.*);

	always #10 clk = ~clk;

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		error_count++;
		$display("result %0d: %s got %h expected %h", result_count, what, got, want);
	endtask

	// target of an access by address, before any internal storage is touched
	function automatic logic [2:0] map_target(logic [15:0] a, logic wr, logic [7:0] d);
		if (a < 16'h8000)
			return (!wr && boot_on_copy && a < 16'h0100) ?
				mmbd_pkg::TGT_BOOT : mmbd_pkg::TGT_CART;
		if (a <= 16'h9FFF) return mmbd_pkg::TGT_VIDEO;
		if (a <= 16'hBFFF) return mmbd_pkg::TGT_CART;
		if (a <= 16'hFDFF) return mmbd_pkg::TGT_INTERNAL;
		if (a <= 16'hFE9F) return mmbd_pkg::TGT_VIDEO;
		if (a <= 16'hFEFF) return mmbd_pkg::TGT_UNMAPPED;
		if (a < mmbd_pkg::ADDR_HRAM_LO) begin
			if (a == mmbd_pkg::ADDR_JOYPAD) return mmbd_pkg::TGT_JOYPAD;
			if (a >= 16'hFF04 && a <= 16'hFF07) return mmbd_pkg::TGT_TIMER;
			if (a == mmbd_pkg::ADDR_IF) return mmbd_pkg::TGT_INTERNAL;
			if (wr && a == mmbd_pkg::ADDR_DMA) return mmbd_pkg::TGT_DMA;
			// boot-off only takes a nonzero byte
			if (wr && a == mmbd_pkg::ADDR_BOOT_OFF && d != 8'h00)
				return mmbd_pkg::TGT_INTERNAL;
			if (a >= 16'hFF40 && a <= 16'hFF4B) return mmbd_pkg::TGT_VIDEO;
			return mmbd_pkg::TGT_UNMAPPED;
		end
		return mmbd_pkg::TGT_INTERNAL;
	endfunction

	// expected result of one access, updating our storage copy on the way
	function automatic bus_result_t decode_access(bus_access_t acc);
		bus_result_t r;
		logic wr;
		logic [15:0] a;
		a = acc.address;
		r.target = mmbd_pkg::TGT_UNMAPPED;
		r.read_data = mmbd_pkg::BYTE_UNMAPPED;
		r.forward_address = 16'h0000;
		r.forward_write = 1'b0;
		r.forward_data = 8'h00;
		if (acc.operation == mmbd_pkg::OP_IRQ) begin
			if_copy = if_copy | (8'd1 << acc.interrupt_bit);
			r.target = mmbd_pkg::TGT_INTERNAL;
			r.read_data = 8'h00;
		end else if (acc.operation == mmbd_pkg::OP_READ ||
				acc.operation == mmbd_pkg::OP_WRITE) begin
			wr = (acc.operation == mmbd_pkg::OP_WRITE);
			r.target = map_target(a, wr, acc.write_data);
			if (r.target == mmbd_pkg::TGT_INTERNAL) begin
				r.read_data = 8'h00;
				if (a >= mmbd_pkg::ADDR_WRAM_LO && a <= 16'hFDFF) begin
					// echo window aliases onto work ram through the low 13 bits
					if (wr) wram_copy[a[12:0]] = acc.write_data;
					else r.read_data = wram_copy[a[12:0]];
				end else if (a == mmbd_pkg::ADDR_IF) begin
					if (wr) if_copy = acc.write_data;
					else r.read_data = if_copy;
				end else if (a == mmbd_pkg::ADDR_BOOT_OFF) begin
					boot_on_copy = 1'b0;
				end else if (a >= mmbd_pkg::ADDR_HRAM_LO && a < mmbd_pkg::ADDR_IE) begin
					if (wr) hram_copy[a[6:0]] = acc.write_data;
					else r.read_data = hram_copy[a[6:0]];
				end else if (a == mmbd_pkg::ADDR_IE) begin
					if (wr) ie_copy = acc.write_data;
					else r.read_data = ie_copy;
				end
			end else if (r.target != mmbd_pkg::TGT_UNMAPPED) begin
				r.read_data = 8'h00;
				r.forward_address = a;
				r.forward_write = wr;
				r.forward_data = wr ? acc.write_data : 8'h00;
			end
		end
		return r;
	endfunction

	task automatic push_access(logic [1:0] op, logic [15:0] a, logic [7:0] d, logic [2:0] b);
		bus_access_t acc;
		acc.operation = op;
		acc.address = a;
		acc.write_data = d;
		acc.interrupt_bit = b;
		acc.drain_first = 1'b0;
		access_queue.push_back(acc);
	endtask

	// one random access, weighted toward the internal stores so that
	// reads come back to addresses that were written
	function automatic bus_access_t random_access(int idx);
		bus_access_t acc;
		int pick;
		int offs;
		pick = $urandom_range(0, 99);
		if (pick < 45) acc.operation = mmbd_pkg::OP_READ;
		else if (pick < 85) acc.operation = mmbd_pkg::OP_WRITE;
		else if (pick < 97) acc.operation = mmbd_pkg::OP_IRQ;
		else acc.operation = OP_UNDEF;
		acc.write_data = 8'($urandom_range(0, 255));
		acc.interrupt_bit = 3'($urandom_range(0, 7));
		acc.drain_first = (idx == DRAIN_AT);
		// small pool of work ram offsets gives read-after-write hits
		offs = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : -1;
		pick = $urandom_range(0, 99);
		if (pick < 6) acc.address = 16'($urandom_range(0, 16'h00FF));
		else if (pick < 16) acc.address = 16'($urandom_range(16'h0100, 16'h7FFF));
		else if (pick < 24) acc.address = 16'($urandom_range(16'h8000, 16'h9FFF));
		else if (pick < 28) acc.address = 16'($urandom_range(16'hA000, 16'hBFFF));
		else if (pick < 48)
			acc.address = mmbd_pkg::ADDR_WRAM_LO +
				16'(offs >= 0 ? offs : $urandom_range(0, 16'h1FFF));
		else if (pick < 58)
			acc.address = mmbd_pkg::ADDR_ECHO_LO +
				16'(offs >= 0 ? offs : $urandom_range(0, 16'h1DFF));
		else if (pick < 63) acc.address = 16'($urandom_range(16'hFE00, 16'hFE9F));
		else if (pick < 67) acc.address = 16'($urandom_range(16'hFEA0, 16'hFEFF));
		else if (pick < 79) begin
			case ($urandom_range(0, 8))
				0: acc.address = mmbd_pkg::ADDR_JOYPAD;
				1: acc.address = 16'($urandom_range(16'hFF01, 16'hFF03));
				2: acc.address = 16'($urandom_range(16'hFF04, 16'hFF07));
				3: acc.address = mmbd_pkg::ADDR_IF;
				4: acc.address = 16'($urandom_range(16'hFF40, 16'hFF4B));
				5: acc.address = mmbd_pkg::ADDR_DMA;
				6: acc.address = mmbd_pkg::ADDR_BOOT_OFF;
				default: acc.address = 16'($urandom_range(16'hFF01, 16'hFF7F));
			endcase
		end else if (pick < 93)
			acc.address = mmbd_pkg::ADDR_HRAM_LO + 16'($urandom_range(0, 126));
		else if (pick < 96) acc.address = mmbd_pkg::ADDR_IE;
		else acc.address = 16'($urandom_range(0, 16'hFFFF));
		// keep the boot rom on until its planned switch-off
		if (idx < BOOT_OFF_AT && acc.address == mmbd_pkg::ADDR_BOOT_OFF)
			acc.write_data = 8'h00;
		if (idx == BOOT_OFF_AT) begin
			acc.operation = mmbd_pkg::OP_WRITE;
			acc.address = mmbd_pkg::ADDR_BOOT_OFF;
			acc.write_data = 8'($urandom_range(1, 255));
		end
		return acc;
	endfunction

	// driver: offers items in bursts with gaps, holding each until taken
	always @(negedge clk) begin : driver
		logic want_valid;
		bus_access_t head;
		want_valid = in_valid;
		if (arst_n && (!in_valid || taken_count == offered_count)) begin
			// the previous item went in, or nothing was offered
			want_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (access_queue.size() > 0 &&
					!(access_queue[0].drain_first && expected_results.size() != 0)) begin
				head = access_queue.pop_front();
				operation <= head.operation;
				address <= head.address;
				write_data <= head.write_data;
				interrupt_bit <= head.interrupt_bit;
				want_valid = 1'b1;
				offered_count++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
		in_valid <= want_valid;
	end

	// receiver: changing stall patterns plus one long hold-off
	always @(negedge clk) begin : receiver
		logic rdy;
		rdy = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!hold_done && taken_count >= HOLD_AFTER) begin
			// sender keeps offering, so the block fills and stalls its input
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			rdy = 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_ALWAYS: rdy = 1'b1;
				RX_RANDOM: rdy = 1'($urandom_range(0, 1));
				RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
				RX_TOGGLE: rdy = ~out_ready;
				default: rdy = 1'b1;
			endcase
		end
		out_ready <= rdy;
	end

	// monitor: checks each result taken, then predicts each item taken
	always @(posedge clk) begin : monitor
		bus_result_t want;
		bus_access_t acc;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected, target", 16'(target), 16'h0);
				end else begin
					want = expected_results.pop_front();
					if (target !== want.target)
						report_mismatch("target", 16'(target), 16'(want.target));
					if (read_data !== want.read_data)
						report_mismatch("read_data", 16'(read_data), 16'(want.read_data));
					if (forward_address !== want.forward_address)
						report_mismatch("forward_address", forward_address, want.forward_address);
					if (forward_write !== want.forward_write)
						report_mismatch("forward_write", 16'(forward_write),
							16'(want.forward_write));
					if (forward_data !== want.forward_data)
						report_mismatch("forward_data", 16'(forward_data), 16'(want.forward_data));
				end
				result_count++;
			end
			if (in_valid && in_ready) begin
				acc.operation = operation;
				acc.address = address;
				acc.write_data = write_data;
				acc.interrupt_bit = interrupt_bit;
				acc.drain_first = 1'b0;
				expected_results.push_back(decode_access(acc));
				taken_count++;
			end
		end
	end

	initial begin : stimulus
		bus_access_t acc;
		for (int i = 0; i < WRAM_WORDS; i++) wram_copy[i] = 8'h00;
		for (int i = 0; i < HRAM_WORDS; i++) hram_copy[i] = 8'h00;
		if_copy = 8'h00;
		ie_copy = 8'h00;
		boot_on_copy = 1'b1;

		// directed part: edges of most regions and the special cases
		push_access(mmbd_pkg::OP_READ, 16'h0000, 8'h00, 3'd0);      // boot rom low edge
		push_access(mmbd_pkg::OP_READ, 16'h00FF, 8'hFF, 3'd7);      // boot rom high edge
		// boot area write goes to cartridge
		push_access(mmbd_pkg::OP_WRITE, 16'h0000, 8'hFF, 3'd0);
		push_access(mmbd_pkg::OP_READ, 16'h7FFF, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_WRITE, 16'h8000, 8'h5A, 3'd0);     // video
		push_access(mmbd_pkg::OP_READ, 16'hBFFF, 8'h00, 3'd0);      // cartridge ram window
		push_access(mmbd_pkg::OP_WRITE, mmbd_pkg::ADDR_WRAM_LO, 8'hA5, 3'd0);
		// echo of the byte above
		push_access(mmbd_pkg::OP_READ, mmbd_pkg::ADDR_ECHO_LO, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_WRITE, 16'hFDFF, 8'h3C, 3'd0);     // top of echo window
		push_access(mmbd_pkg::OP_READ, 16'hDDFF, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_READ, 16'hFE9F, 8'h00, 3'd0);      // sprite memory edge
		push_access(mmbd_pkg::OP_READ, 16'hFEA0, 8'h00, 3'd0);      // unmapped read
		push_access(mmbd_pkg::OP_WRITE, 16'hFEFF, 8'h77, 3'd0);     // unmapped write dropped
		push_access(mmbd_pkg::OP_WRITE, mmbd_pkg::ADDR_JOYPAD, 8'h30, 3'd0);
		push_access(mmbd_pkg::OP_READ, 16'hFF07, 8'h00, 3'd0);      // timer
		// interrupt request, top bit
		push_access(mmbd_pkg::OP_IRQ, 16'hFFFF, 8'hFF, 3'd7);
		push_access(mmbd_pkg::OP_IRQ, 16'h0000, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_READ, mmbd_pkg::ADDR_IF, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_WRITE, mmbd_pkg::ADDR_DMA, 8'hC1, 3'd0);     // dma start
		// dma register reads as video
		push_access(mmbd_pkg::OP_READ, mmbd_pkg::ADDR_DMA, 8'h00, 3'd0);
		// zero boot-off ignored
		push_access(mmbd_pkg::OP_WRITE, mmbd_pkg::ADDR_BOOT_OFF, 8'h00, 3'd0);
		// boot-off reads unmapped
		push_access(mmbd_pkg::OP_READ, mmbd_pkg::ADDR_BOOT_OFF, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_WRITE, 16'hFFFE, 8'hFF, 3'd0);     // high ram top
		push_access(mmbd_pkg::OP_READ, 16'hFFFE, 8'h00, 3'd0);
		push_access(mmbd_pkg::OP_WRITE, mmbd_pkg::ADDR_IE, 8'hFF, 3'd0);
		push_access(OP_UNDEF, mmbd_pkg::ADDR_IE, 8'h12, 3'd5);      // undefined operation

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			acc = random_access(i);
			if (i == 0) acc.drain_first = 1'b1;
			access_queue.push_back(acc);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all items in, then all results out, then a quiet tail
		while (access_queue.size() != 0 || in_valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results still missing", 16'h0, 16'(expected_results.size()));
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// covers the clearing pass, every stall pattern and the long hold-off many times over
	initial begin : watchdog
		#15_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
